/* design/cmr_pkg.sv */
// Shared widths and types for the Cayley rotation map.
package cmr_pkg;
  localparam int IN_W  = 24;
  localparam int OUT_W = 18;
  localparam int LANES = 9;

  typedef logic signed [IN_W-1:0]  eta_t;
  typedef logic        [OUT_W-1:0] rot_t;

  typedef struct packed {
    logic neg;
    logic sat;
  } lane_flags_t;
endpackage

/* design/cmr_in_if.sv */
// Input channel: one parameter vector per beat.
interface cmr_in_if;
  logic valid;
  logic ready;
  cmr_pkg::eta_t eta_x;
  cmr_pkg::eta_t eta_y;
  cmr_pkg::eta_t eta_z;
  modport source(output valid, eta_x, eta_y, eta_z, input ready);
  modport sink(input valid, eta_x, eta_y, eta_z, output ready);
endinterface

/* design/cmr_out_if.sv */
// Output channel: one rotation matrix per beat.
interface cmr_out_if;
  logic valid;
  logic ready;
  cmr_pkg::rot_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
  modport source(output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, input ready);
  modport sink(input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, output ready);
endinterface

/* design/cayley_map_rotation.sv */
// Cayley map: eta (Q7.IN_FRAC_BITS) to a 3x3 rotation matrix (Q1.OUT_FRAC_BITS),
// rounded to nearest with ties away from zero. Each vector passes two arithmetic
// stages, one magnitude stage, one divider stage per quotient bit and one
// rounding stage before its matrix appears at the output.
// Throughput is one vector per cycle; the whole pipeline holds while a result
// waits at the output.
module cayley_map_rotation #(
  parameter int IN_FRAC_BITS  = 16,
  parameter int OUT_FRAC_BITS = 16
) (
  input logic      clk,
  input logic      rst,
  cmr_in_if.sink   eta_in,
  cmr_out_if.source rot_out
);
  import cmr_pkg::*;

  localparam int NW = (2 * IN_FRAC_BITS + 4 > 51) ? 2 * IN_FRAC_BITS + 4 : 51;
  localparam int PW = 2 * IN_W;

  logic en;
  assign en           = !rot_out.valid || rot_out.ready;
  assign eta_in.ready = en;

  // stage 1: products
  logic                 v1;
  logic signed [PW-1:0] pxx, pyy, pzz, pxy, pxz, pyz;
  eta_t                 ex1, ey1, ez1;

  // stage 2: numerators and denominator
  logic                 v2;
  logic signed [NW-1:0] num [LANES];
  logic        [NW-1:0] den;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= eta_in.valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxx <= eta_in.eta_x * eta_in.eta_x;
      pyy <= eta_in.eta_y * eta_in.eta_y;
      pzz <= eta_in.eta_z * eta_in.eta_z;
      pxy <= eta_in.eta_x * eta_in.eta_y;
      pxz <= eta_in.eta_x * eta_in.eta_z;
      pyz <= eta_in.eta_y * eta_in.eta_z;
      ex1 <= eta_in.eta_x;
      ey1 <= eta_in.eta_y;
      ez1 <= eta_in.eta_z;
    end
  end

  logic signed [NW-1:0] four_s2, sq, dg, kx, ky, kz;
  assign four_s2 = NW'(1) <<< (2 * IN_FRAC_BITS + 2);
  assign sq      = NW'(pxx) + NW'(pyy) + NW'(pzz);
  assign dg      = four_s2 - sq;
  assign kx      = NW'(ex1) <<< (IN_FRAC_BITS + 2);
  assign ky      = NW'(ey1) <<< (IN_FRAC_BITS + 2);
  assign kz      = NW'(ez1) <<< (IN_FRAC_BITS + 2);

  always_ff @(posedge clk) begin
    if (en) begin
      den    <= NW'(four_s2 + sq);
      num[0] <= dg + (NW'(pxx) <<< 1);
      num[1] <= (NW'(pxy) <<< 1) - kz;
      num[2] <= (NW'(pxz) <<< 1) + ky;
      num[3] <= (NW'(pxy) <<< 1) + kz;
      num[4] <= dg + (NW'(pyy) <<< 1);
      num[5] <= (NW'(pyz) <<< 1) - kx;
      num[6] <= (NW'(pxz) <<< 1) - ky;
      num[7] <= (NW'(pyz) <<< 1) + kx;
      num[8] <= dg + (NW'(pzz) <<< 1);
    end
  end

  rot_t res [LANES];

  cmr_divider #(.NW(NW), .OF(OUT_FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .num      (num),
    .den      (den),
    .out_valid(rot_out.valid),
    .res      (res)
  );

  assign rot_out.r00 = res[0];
  assign rot_out.r01 = res[1];
  assign rot_out.r02 = res[2];
  assign rot_out.r10 = res[3];
  assign rot_out.r11 = res[4];
  assign rot_out.r12 = res[5];
  assign rot_out.r20 = res[6];
  assign rot_out.r21 = res[7];
  assign rot_out.r22 = res[8];

  localparam logic signed [OUT_W-1:0] ONE =
    (OUT_FRAC_BITS > 16) ? '0 : OUT_W'(1 << OUT_FRAC_BITS);

  a_ready: assert property (@(posedge clk) disable iff (rst)
    eta_in.ready == (!rot_out.valid || rot_out.ready))
    else $error("input ready does not follow output stall");
  a_reset: assert property (@(posedge clk) rst |=> !rot_out.valid)
    else $error("result valid after reset");
  a_range: assert property (@(posedge clk) disable iff (rst)
    (rot_out.valid && OUT_FRAC_BITS <= 16) |->
      ($signed(rot_out.r00) <= ONE && $signed(rot_out.r00) >= -ONE &&
       $signed(rot_out.r11) <= ONE && $signed(rot_out.r11) >= -ONE))
    else $error("diagonal entry out of range");
endmodule

/* design/cmr_divider.sv */
// Pipelined restoring divider for nine numerators over one shared denominator.
module cmr_divider #(
  parameter int NW = 51,
  parameter int OF = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [NW-1:0] num [cmr_pkg::LANES],
  input  logic        [NW-1:0] den,
  output logic                 out_valid,
  output cmr_pkg::rot_t        res [cmr_pkg::LANES]
);
  import cmr_pkg::*;

  localparam int QW = (OF + 1 > OUT_W) ? OF + 1 : OUT_W;

  logic [NW-1:0]  rem  [0:OF][LANES];
  logic [QW-1:0]  quo  [0:OF][LANES];
  lane_flags_t    fl   [0:OF][LANES];
  logic [NW-1:0]  dd   [0:OF];
  logic [OF:0]    vld;

  logic [NW-1:0]  mag0 [LANES];
  lane_flags_t    fl0  [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      fl0[l].neg = num[l][NW-1];
      mag0[l]    = fl0[l].neg ? NW'(-num[l]) : NW'(num[l]);
      fl0[l].sat = (mag0[l] >= den);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[OF-1:0], in_valid};
      out_valid <= vld[OF];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd[0] <= den;
      for (int l = 0; l < LANES; l++) begin
        rem[0][l] <= mag0[l];
        quo[0][l] <= '0;
        fl[0][l]  <= fl0[l];
      end
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= OF; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) dd[k] <= dd[k-1];
    end
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [NW:0] sh;
      logic        ge;
      assign sh = {rem[k-1][l], 1'b0};
      assign ge = (sh >= {1'b0, dd[k-1]});
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k][l] <= ge ? NW'(sh - {1'b0, dd[k-1]}) : sh[NW-1:0];
          quo[k][l] <= {quo[k-1][l][QW-2:0], ge};
          fl[k][l]  <= fl[k-1][l];
        end
      end
    end
  end

  // round half away from zero, saturate, apply sign
  for (genvar l = 0; l < LANES; l++) begin : g_fin
    logic          rnd;
    logic [QW-1:0] qf;
    logic [QW-1:0] qs;
    assign rnd = ({rem[OF][l], 1'b0} >= {1'b0, dd[OF]});
    assign qf  = fl[OF][l].sat ? (QW'(1) << OF) : (quo[OF][l] + QW'(rnd));
    assign qs  = fl[OF][l].neg ? (~qf + QW'(1)) : qf;
    always_ff @(posedge clk) begin
      if (en) res[l] <= qs[OUT_W-1:0];
    end
  end
endmodule
